FILE: sv/cia_pkg.sv
// Shared constants and types for the complex integer arithmetic unit.
package cia_pkg;

   localparam int PartWidthDefault = 16;
   localparam int OutWidth         = 33;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

FILE: sv/complex_integer_alu_core.sv
// Pipelined complex add, subtract, multiply and divide unit.
//
//  channel | direction | tdata fields (lowest bit first)
//  req     | in        | mode[2], a_re[16], a_im[16], b_re[16], b_im[16] (66 bits -> 72)
//  rsp     | out       | out_re[33], out_im[33], div_zero[1] (67 bits -> 72)
//
// A req beat passes stages 0-3, the divider stages and the output register.
// One beat enters per cycle unless stalled; the restoring divider unrolls into one
// quotient-bit stage per pipeline stage, each holding a subtract and compare per part.
// The whole pipe advances only when its last stage is empty or rsp is taken; a stall
// holds every stage, so nothing is lost or repeated.
// Reset clears the valid bits only.
module complex_integer_alu_core #(
   parameter int PART_WIDTH = cia_pkg::PartWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // mode, a_re, a_im, b_re, b_im
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // out_re, out_im, div_zero
);
   import cia_pkg::*;

   localparam int PW  = PART_WIDTH;
   localparam int PRW = 2 * PW + 1;        // product / sum of products width (signed)
   localparam int MW  = 2 * PW + 1;        // magnitude width (unsigned)
   localparam int NDS = MW;                // divider stages, one quotient bit each
   localparam int NST = 4 + NDS + 1;       // total stages

   // Whole pipe advances together; the final stage is the output register.
   logic advance;
   logic [NST-1:0] vld_ff, vld_in;
   assign advance    = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[NST-1];

   always_comb begin
      vld_in = {vld_ff[NST-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: capture operands; keep only the low PART_WIDTH bits of each 16-bit field.
   op_type             op0_ff;
   logic signed [PW-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         op0_ff <= op_type'(req_tdata[1:0]);
         ar0_ff <= PW'(req_tdata[17:2]);
         ai0_ff <= PW'(req_tdata[33:18]);
         br0_ff <= PW'(req_tdata[49:34]);
         bi0_ff <= PW'(req_tdata[65:50]);
      end
   end

   // Stage 1: six products plus add/sub results.
   op_type op1_ff;
   logic signed [2*PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, d_rr_ff, d_ii_ff;
   logic signed [PW:0]     s_re_ff, s_im_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff  <= op0_ff;
         p_rr_ff <= ar0_ff * br0_ff;
         p_ii_ff <= ai0_ff * bi0_ff;
         p_ri_ff <= ar0_ff * bi0_ff;
         p_ir_ff <= ai0_ff * br0_ff;
         d_rr_ff <= br0_ff * br0_ff;
         d_ii_ff <= bi0_ff * bi0_ff;
         if (op0_ff == OP_SUB) begin
            s_re_ff <= {ar0_ff[PW-1], ar0_ff} - {br0_ff[PW-1], br0_ff};
            s_im_ff <= {ai0_ff[PW-1], ai0_ff} - {bi0_ff[PW-1], bi0_ff};
         end else begin
            s_re_ff <= {ar0_ff[PW-1], ar0_ff} + {br0_ff[PW-1], br0_ff};
            s_im_ff <= {ai0_ff[PW-1], ai0_ff} + {bi0_ff[PW-1], bi0_ff};
         end
      end
   end

   // Stage 2: combine products.
   op_type op2_ff;
   logic signed [PRW-1:0] mul_re_ff, mul_im_ff, num_re_ff, num_im_ff;
   logic [MW-1:0]         den_ff;
   logic signed [PW:0]    s2_re_ff, s2_im_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         op2_ff    <= op1_ff;
         mul_re_ff <= PRW'(p_rr_ff) - PRW'(p_ii_ff);
         mul_im_ff <= PRW'(p_ri_ff) + PRW'(p_ir_ff);
         num_re_ff <= PRW'(p_rr_ff) + PRW'(p_ii_ff);
         num_im_ff <= PRW'(p_ir_ff) - PRW'(p_ri_ff);
         den_ff    <= MW'($unsigned(d_rr_ff)) + MW'($unsigned(d_ii_ff));
         s2_re_ff  <= s_re_ff;
         s2_im_ff  <= s_im_ff;
      end
   end

   // Divider: restoring, one quotient bit per stage, both parts in parallel.
   logic [MW-1:0] rr_ff [NDS+1];
   logic [MW-1:0] ri_ff [NDS+1];
   logic [MW-1:0] qr_ff [NDS+1];
   logic [MW-1:0] qi_ff [NDS+1];
   logic [MW-1:0] dv_ff [NDS+1];
   logic          sr_ff [NDS+1];
   logic          si_ff [NDS+1];
   logic          dz_ff [NDS+1];
   logic          isd_ff [NDS+1];
   logic signed [PRW-1:0] xr_ff [NDS+1];
   logic signed [PRW-1:0] xi_ff [NDS+1];

   // Stage 3: magnitudes and the non-divide result, loaded as the divider's first entry.
   always_ff @(posedge clock) begin
      if (advance) begin
         rr_ff[0]  <= '0;
         ri_ff[0]  <= '0;
         qr_ff[0]  <= num_re_ff[PRW-1] ? MW'(-num_re_ff) : MW'(num_re_ff);
         qi_ff[0]  <= num_im_ff[PRW-1] ? MW'(-num_im_ff) : MW'(num_im_ff);
         dv_ff[0]  <= den_ff;
         sr_ff[0]  <= num_re_ff[PRW-1];
         si_ff[0]  <= num_im_ff[PRW-1];
         dz_ff[0]  <= (op2_ff == OP_DIV) && (den_ff == '0);
         isd_ff[0] <= (op2_ff == OP_DIV);
         if (op2_ff == OP_MUL) begin
            xr_ff[0] <= mul_re_ff;
            xi_ff[0] <= mul_im_ff;
         end else begin
            xr_ff[0] <= PRW'(s2_re_ff);
            xi_ff[0] <= PRW'(s2_im_ff);
         end
      end
   end

   for (genvar g = 0; g < NDS; g++) begin : g_div
      logic [MW:0] tr, ti, dr, di;
      always_comb begin
         tr = {rr_ff[g], qr_ff[g][MW-1]};
         ti = {ri_ff[g], qi_ff[g][MW-1]};
         dr = tr - {1'b0, dv_ff[g]};
         di = ti - {1'b0, dv_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rr_ff[g+1]  <= dr[MW] ? tr[MW-1:0] : dr[MW-1:0];
            ri_ff[g+1]  <= di[MW] ? ti[MW-1:0] : di[MW-1:0];
            qr_ff[g+1]  <= {qr_ff[g][MW-2:0], ~dr[MW]};
            qi_ff[g+1]  <= {qi_ff[g][MW-2:0], ~di[MW]};
            dv_ff[g+1]  <= dv_ff[g];
            sr_ff[g+1]  <= sr_ff[g];
            si_ff[g+1]  <= si_ff[g];
            dz_ff[g+1]  <= dz_ff[g];
            isd_ff[g+1] <= isd_ff[g];
            xr_ff[g+1]  <= xr_ff[g];
            xi_ff[g+1]  <= xi_ff[g];
         end
      end
   end

   // Output stage: apply signs, pick result, truncate to the output width.
   logic [MW:0] qre, qim, sre, sim;
   logic [OutWidth-1:0] ore, oim;
   always_comb begin
      qre = {1'b0, qr_ff[NDS]};
      qim = {1'b0, qi_ff[NDS]};
      sre = sr_ff[NDS] ? -qre : qre;
      sim = si_ff[NDS] ? -qim : qim;
      if (!isd_ff[NDS]) begin
         ore = OutWidth'(unsigned'(PRW'(xr_ff[NDS])) | {OutWidth{1'b0}})
               | ({OutWidth{xr_ff[NDS][PRW-1]}} & ~OutWidth'({PRW{1'b1}}));
         oim = OutWidth'(unsigned'(PRW'(xi_ff[NDS])) | {OutWidth{1'b0}})
               | ({OutWidth{xi_ff[NDS][PRW-1]}} & ~OutWidth'({PRW{1'b1}}));
      end else if (dz_ff[NDS]) begin
         ore = '0;
         oim = '0;
      end else begin
         ore = OutWidth'(sre) | ({OutWidth{sre[MW]}} & ~OutWidth'({(MW+1){1'b1}}));
         oim = OutWidth'(sim) | ({OutWidth{sim[MW]}} & ~OutWidth'({(MW+1){1'b1}}));
      end
   end

   logic [71:0] out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= {5'b0, dz_ff[NDS] & isd_ff[NDS], oim, ore};
      end
   end
   assign rsp_tdata = out_ff;

endmodule

FILE: dv/cia_checker.sv
// Stream checker for the complex integer arithmetic unit: predicts each rsp beat and compares.
module cia_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          outstanding,
   output int          mismatches
);
   import cia_pkg::*;

   typedef struct packed {
      logic              div_zero;
      logic [OutWidth-1:0] im;
      logic [OutWidth-1:0] re;
   } cplx_result_type;

   cplx_result_type result_q[$];

   // Exact complex arithmetic on sign-extended parts, then keep the low 33 bits.
   function automatic cplx_result_type complex_result(input logic [71:0] beat);
      op_type          op;
      longint          ar, ai, br, bi, den, nr, ni, re, im;
      cplx_result_type res;
      op = op_type'(beat[1:0]);
      ar = longint'($signed(beat[17:2]));
      ai = longint'($signed(beat[33:18]));
      br = longint'($signed(beat[49:34]));
      bi = longint'($signed(beat[65:50]));
      re = 0;
      im = 0;
      res.div_zero = 1'b0;
      case (op)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = ar * br - ai * bi;
            im = ar * bi + ai * br;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               res.div_zero = 1'b1;
            end else begin
               nr = ar * br + ai * bi;
               ni = ai * br - ar * bi;
               re = nr / den;
               im = ni / den;
            end
         end
      endcase
      res.re = re[OutWidth-1:0];
      res.im = im[OutWidth-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      cplx_result_type want, got;
      if (reset) begin
         outstanding <= 0;
         mismatches  <= 0;
      end else begin
         if (req_tvalid && req_tready)
            result_q.push_back(complex_result(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[66:0];
            if (result_q.size() == 0) begin
               if (mismatches < 10)
                  $display("rsp beat with nothing expected: %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = result_q.pop_front();
               if (want.re !== got.re || want.im !== got.im
                   || want.div_zero !== got.div_zero) begin
                  if (mismatches < 10)
                     $display("mismatch: want re=%h im=%h dz=%b, got re=%h im=%h dz=%b",
                              want.re, want.im, want.div_zero,
                              got.re, got.im, got.div_zero);
                  mismatches <= mismatches + 1;
               end
            end
         end
         outstanding <= result_q.size();
      end
   end

endmodule

FILE: dv/tb_top.sv
// Top of the complex integer arithmetic unit testbench: clock, stimulus and verdict.
module tb_top;
   import cia_pkg::*;

   localparam int RandomBeats = 630;
   localparam int CycleLimit  = 300000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // mode, a_re, a_im, b_re, b_im
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // out_re, out_im, div_zero
   int          outstanding;
   int          mismatches;
   int          cycles = 0;
   bit          long_stall;  // ask the receiver for one long hold-off
   bit          quiet;       // no idling or back-pressure in the closing stretch

   complex_integer_alu_core dut (.*);

   cia_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up well past the slowest legal run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [71:0] pack_req(input op_type op, input logic [15:0] ar,
                                            input logic [15:0] ai, input logic [15:0] br,
                                            input logic [15:0] bi);
      return {6'b0, bi, br, ai, ar, op};
   endfunction

   // Bias operands toward the extremes and small values, where sign slips hide.
   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               3: return 16'hffff;
               default: return 16'h0001;
            endcase
         end
         1, 2: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one beat and hold it until accepted.
   task automatic send_beat(input logic [71:0] beat);
      req_tdata  <= beat;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid for a random burst now and then.
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Receiver: random back-pressure bursts plus one long hold-off on request.
   initial begin
      bit stall_done;
      stall_done = 1'b0;
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (long_stall && !stall_done) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] ar, ai, br, bi;
      op_type      op;
      long_stall = 1'b0;
      quiet      = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes per op, zero divisor, divide by most negative parts.
      for (int k = 0; k < 4; k++) begin
         op = op_type'(k);
         send_beat(pack_req(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
         send_beat(pack_req(op, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
         send_beat(pack_req(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
         send_beat(pack_req(op, 16'h8000, 16'h7fff, 16'hffff, 16'h0001));
         maybe_idle();
      end
      send_beat(pack_req(OP_DIV, 16'h1234, 16'hbeef, 16'h0000, 16'h0000));
      send_beat(pack_req(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_beat(pack_req(OP_DIV, 16'hfff9, 16'h0007, 16'h0002, 16'h0000));
      send_beat(pack_req(OP_DIV, 16'h0007, 16'hfff9, 16'h0000, 16'hfffe));
      send_beat(pack_req(OP_DIV, 16'h0001, 16'h0001, 16'h8000, 16'h0000));
      send_beat(pack_req(OP_MUL, 16'h0000, 16'hffff, 16'h0000, 16'hffff));

      for (int n = 0; n < RandomBeats; n++) begin
         if (n == 200)
            long_stall = 1'b1;
         if (n == 400) begin
            // Let the pipe drain completely before resuming.
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if (n == RandomBeats - 120)
            quiet = 1'b1;
         op = op_type'($urandom_range(0, 3));
         ar = pick_part();
         ai = pick_part();
         br = pick_part();
         bi = pick_part();
         if (op == OP_DIV && $urandom_range(0, 7) == 0) begin
            br = '0;
            bi = '0;
         end
         send_beat(pack_req(op, ar, ai, br, bi));
         maybe_idle();
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
